### rtl/lhc_pkg.sv
// Shared types and constants for the LRU handle cache.
`default_nettype none

package lhc_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned STAMP_W    = 64;
   localparam int unsigned REQ_DATA_W = 136;
   localparam int unsigned RSP_DATA_W = 72;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_HIT           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IMPORT_FAILED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE          = 3'd4;

   typedef enum logic [1:0] {
      OP_LOOKUP  = 2'd0,
      OP_RELEASE = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_REJECT  = 2'd3
   } op_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_run;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_kind_type kind;
      logic        scan_done;
      logic        out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/lhc_ctrl.sv
// Sequencing state machine for the LRU handle cache.
`default_nettype none

module lhc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire lhc_pkg::dp_stat_type stat,
   output lhc_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.kind == lhc_pkg::OP_LOOKUP || stat.kind == lhc_pkg::OP_RELEASE) begin
               cmd.scan_run = 1'b1;
               if (stat.scan_done) begin
                  state_in = S_COMMIT;
               end
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/lhc_dp.sv
// Entry store, scan unit and response register of the LRU handle cache.
`default_nettype none

module lhc_dp #(
   parameter int unsigned ENTRIES  = 64,
   parameter int unsigned KEY_BITS = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire lhc_pkg::ctl_cmd_type              cmd,
   output lhc_pkg::dp_stat_type                   stat,
   input  wire [lhc_pkg::REQ_DATA_W-1:0]          req_tdata,
   input  wire [lhc_pkg::CMD_W-1:0]               req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [lhc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [lhc_pkg::STATUS_W-1:0]           rsp_tuser
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned PAD_W = lhc_pkg::RSP_DATA_W - 2 * lhc_pkg::WORD_W - 1;

   // request fields
   logic [lhc_pkg::WORD_W-1:0] f_key, f_fd, f_size, f_handle;
   logic                       f_present;
   logic [KEY_BITS-1:0]        key_ext;

   assign f_key     = req_tdata[31:0];
   assign f_present = req_tdata[32];
   assign f_fd      = req_tdata[64:33];
   assign f_size    = req_tdata[96:65];
   assign f_handle  = req_tdata[128:97];

   generate
      if (KEY_BITS <= lhc_pkg::WORD_W) begin : g_key_trunc
         assign key_ext = f_key[KEY_BITS-1:0];
      end else begin : g_key_ext
         assign key_ext = {{(KEY_BITS - lhc_pkg::WORD_W){1'b0}}, f_key};
      end
   endgenerate

   // captured request
   logic [lhc_pkg::CMD_W-1:0]  cmd_ff;
   logic                       ok_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic [lhc_pkg::WORD_W-1:0] fresh_ff;

   // entry store
   logic [KEY_BITS-1:0]         key_mem    [ENTRIES];
   logic [lhc_pkg::WORD_W-1:0]  handle_mem [ENTRIES];
   logic [lhc_pkg::STAMP_W-1:0] stamp_mem  [ENTRIES];
   logic [ENTRIES-1:0]          valid_ff, valid_in;
   logic [lhc_pkg::STAMP_W-1:0] use_cnt_ff, use_cnt_in;

   // scan pipeline
   logic [CW-1:0]               issue_cnt_ff, issue_cnt_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [IW-1:0]               rd_idx_ff;
   logic [KEY_BITS-1:0]         rd_key_ff;
   logic [lhc_pkg::WORD_W-1:0]  rd_handle_ff;
   logic [lhc_pkg::STAMP_W-1:0] rd_stamp_ff;
   logic                        rd_en;
   logic [IW-1:0]               rd_addr;
   logic                        ent_valid;

   // scan results
   logic                        hit_found_ff, hit_found_in;
   logic [IW-1:0]               hit_idx_ff, hit_idx_in;
   logic [lhc_pkg::WORD_W-1:0]  hit_handle_ff, hit_handle_in;
   logic                        free_found_ff, free_found_in;
   logic [IW-1:0]               free_idx_ff, free_idx_in;
   logic                        old_found_ff, old_found_in;
   logic [IW-1:0]               old_idx_ff, old_idx_in;
   logic [lhc_pkg::STAMP_W-1:0] old_stamp_ff, old_stamp_in;
   logic [lhc_pkg::WORD_W-1:0]  old_handle_ff, old_handle_in;

   // commit
   lhc_pkg::op_kind_type        kind;
   logic [IW-1:0]               ins_slot, wr_idx;
   logic                        key_we, handle_we, stamp_we;
   logic [lhc_pkg::STAMP_W-1:0] stamp_next;
   logic [lhc_pkg::STATUS_W-1:0] st_in;
   logic [lhc_pkg::WORD_W-1:0]  hdl_in, ev_hdl_in;
   logic                        ev_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lhc_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [lhc_pkg::WORD_W-1:0]   rsp_handle_ff, rsp_ev_handle_ff;
   logic                         rsp_evicted_ff;

   always_comb begin
      unique case (cmd_ff)
         lhc_pkg::CMD_LOOKUP:  kind = ok_ff ? lhc_pkg::OP_LOOKUP : lhc_pkg::OP_REJECT;
         lhc_pkg::CMD_RELEASE: kind = lhc_pkg::OP_RELEASE;
         lhc_pkg::CMD_FLUSH:   kind = lhc_pkg::OP_FLUSH;
         default:              kind = lhc_pkg::OP_REJECT;
      endcase
   end

   assign rd_en     = cmd.scan_run && (issue_cnt_ff != CW'(ENTRIES));
   assign rd_addr   = issue_cnt_ff[IW-1:0];
   assign ent_valid = valid_ff[rd_idx_ff];

   assign stat.kind      = kind;
   assign stat.scan_done = (issue_cnt_ff == CW'(ENTRIES)) && !rd_vld_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // scan: first match, first free slot, smallest stamp (lowest index on ties)
   always_comb begin
      issue_cnt_in  = issue_cnt_ff;
      rd_vld_in     = 1'b0;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_handle_in = hit_handle_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_stamp_in  = old_stamp_ff;
      old_handle_in = old_handle_ff;
      if (cmd.load_req) begin
         issue_cnt_in  = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         old_found_in  = 1'b0;
      end else begin
         if (rd_en) begin
            issue_cnt_in = issue_cnt_ff + CW'(1);
            rd_vld_in    = 1'b1;
         end
         if (rd_vld_ff) begin
            if (ent_valid && rd_key_ff == key_ff && !hit_found_ff) begin
               hit_found_in  = 1'b1;
               hit_idx_in    = rd_idx_ff;
               hit_handle_in = rd_handle_ff;
            end
            if (!ent_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
            if (ent_valid && (!old_found_ff || rd_stamp_ff < old_stamp_ff)) begin
               old_found_in  = 1'b1;
               old_idx_in    = rd_idx_ff;
               old_stamp_in  = rd_stamp_ff;
               old_handle_in = rd_handle_ff;
            end
         end
      end
   end

   // commit: table update and response
   assign ins_slot   = free_found_ff ? free_idx_ff : old_idx_ff;
   assign wr_idx     = hit_found_ff ? hit_idx_ff : ins_slot;
   assign stamp_next = use_cnt_ff + lhc_pkg::STAMP_W'(1);

   always_comb begin
      valid_in   = valid_ff;
      use_cnt_in = use_cnt_ff;
      key_we     = 1'b0;
      handle_we  = 1'b0;
      stamp_we   = 1'b0;
      st_in      = lhc_pkg::ST_REJECTED;
      hdl_in     = '0;
      ev_in      = 1'b0;
      ev_hdl_in  = '0;
      if (cmd.commit) begin
         unique case (kind)
            lhc_pkg::OP_RELEASE: begin
               st_in = lhc_pkg::ST_DONE;
               if (hit_found_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end
            lhc_pkg::OP_FLUSH: begin
               st_in    = lhc_pkg::ST_DONE;
               valid_in = '0;
            end
            lhc_pkg::OP_LOOKUP: begin
               if (hit_found_ff) begin
                  use_cnt_in = stamp_next;
                  stamp_we   = 1'b1;
                  st_in      = lhc_pkg::ST_HIT;
                  hdl_in     = hit_handle_ff;
               end else begin
                  if (!free_found_ff) begin
                     ev_in                = 1'b1;
                     ev_hdl_in            = old_handle_ff;
                     valid_in[old_idx_ff] = 1'b0;
                  end
                  if (fresh_ff == '0) begin
                     st_in = lhc_pkg::ST_IMPORT_FAILED;
                  end else begin
                     use_cnt_in         = stamp_next;
                     valid_in[ins_slot] = 1'b1;
                     key_we             = 1'b1;
                     handle_we          = 1'b1;
                     stamp_we           = 1'b1;
                     st_in              = lhc_pkg::ST_INSERTED;
                     hdl_in             = fresh_ff;
                  end
               end
            end
            default: begin
               st_in = lhc_pkg::ST_REJECTED;
            end
         endcase
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || cmd.commit;

   // memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (handle_we) begin
         handle_mem[wr_idx] <= fresh_ff;
      end
      if (stamp_we) begin
         stamp_mem[wr_idx] <= stamp_next;
      end
      if (rd_en) begin
         rd_key_ff    <= key_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
         rd_stamp_ff  <= stamp_mem[rd_addr];
         rd_idx_ff    <= rd_addr;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         use_cnt_ff    <= '0;
         issue_cnt_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         old_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         use_cnt_ff    <= use_cnt_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         old_found_ff  <= old_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_tuser;
         ok_ff    <= f_present && !f_fd[31] && (f_size != '0) && !f_size[31];
         key_ff   <= key_ext;
         fresh_ff <= f_handle;
      end
      hit_idx_ff    <= hit_idx_in;
      hit_handle_ff <= hit_handle_in;
      free_idx_ff   <= free_idx_in;
      old_idx_ff    <= old_idx_in;
      old_stamp_ff  <= old_stamp_in;
      old_handle_ff <= old_handle_in;
      if (cmd.commit) begin
         rsp_status_ff    <= st_in;
         rsp_handle_ff    <= hdl_in;
         rsp_evicted_ff   <= ev_in;
         rsp_ev_handle_ff <= ev_hdl_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ev_handle_ff, rsp_evicted_ff, rsp_handle_ff};

`ifndef SYNTHESIS
   a_miss_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && kind == lhc_pkg::OP_LOOKUP && !hit_found_ff
      |-> free_found_ff || old_found_ff)
      else $error("miss commit without free or victim slot");

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && kind == lhc_pkg::OP_LOOKUP && !hit_found_ff && fresh_ff != '0
      |=> valid_ff[$past(ins_slot)])
      else $error("inserted entry not marked valid");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && kind == lhc_pkg::OP_FLUSH |=> valid_ff == '0)
      else $error("flush left valid entries");

   a_hit_bumps_counter: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && kind == lhc_pkg::OP_LOOKUP && hit_found_ff
      |=> use_cnt_ff == $past(use_cnt_ff) + lhc_pkg::STAMP_W'(1))
      else $error("hit did not advance use counter");
`endif

endmodule

`default_nettype wire

### rtl/lru_handle_cache.sv
// Top level of the fully associative LRU handle cache.
// A lookup or release scans every entry before it responds
//   (one scan pass reads one entry per cycle from the entry store's read port).
// Reject, flush and unused commands skip the scan and go straight to commit.
// A new request is taken only after the previous one has committed.
// Reset: synchronous, active high; clears all valid bits and the use counter at once.
`default_nettype none

module lru_handle_cache #(
   parameter int unsigned ENTRIES  = 64,   // cache depth, 1 to 1024
   parameter int unsigned KEY_BITS = 32    // low key bits compared, 8 to 64
) (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // buffer_key[31:0], buffer_present[32], plane_fd[64:33], buffer_size[96:65],
   // new_handle[128:97], zero pad [135:129]
   input  wire [lhc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  wire [lhc_pkg::CMD_W-1:0]        req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // handle[31:0], evicted[32], evicted_handle[64:33], zero pad [71:65]
   output logic [lhc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[2:0]
   output logic [lhc_pkg::STATUS_W-1:0]    rsp_tuser
);

   lhc_pkg::ctl_cmd_type cmd;
   lhc_pkg::dp_stat_type stat;

   // Controller: idle / scan / commit sequencing. The response register in
   // the datapath lets a new beat be taken while the last result waits.
   lhc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: request capture, entry memories, linear scan for key match,
   // first free slot and oldest stamp, then a single-cycle commit.
   lhc_dp #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
